// ===== rtl/core/jpeg_app_segment_stripper_macros.svh =====
// Assertion macros shared by the stripper RTL.
`ifndef JPEG_APP_SEGMENT_STRIPPER_MACROS_SVH
`define JPEG_APP_SEGMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define JAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define JAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jas_pkg.sv =====
package jas_pkg;

	// Parser phase codes.
	localparam logic [3:0] PH_SOI_HI  = 4'd0;
	localparam logic [3:0] PH_SOI_LO  = 4'd1;
	localparam logic [3:0] PH_MARK_HI = 4'd2;
	localparam logic [3:0] PH_MARK_LO = 4'd3;
	localparam logic [3:0] PH_LEN_HI  = 4'd4;
	localparam logic [3:0] PH_LEN_LO  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_PASS    = 4'd7;
	localparam logic [3:0] PH_DEAD    = 4'd8;

	// Marker values.
	localparam logic [15:0] MARK_SOI = 16'hFFD8;
	localparam logic [15:0] MARK_SOS = 16'hFFDA;
	localparam logic [15:0] APP_MASK = 16'hFFF0;
	localparam logic [15:0] APP_BASE = 16'hFFE0;

	// Result kinds.
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       kind;
		logic       last;
	} res_t;

endpackage

// ===== rtl/core/jpeg_app_segment_stripper.sv =====
// A result beat is registered and offered on the cycle after its input byte is accepted.
// Throughput: one input byte per cycle while each byte gives at most one beat and the
// output is not stalled; a byte that gives two beats (a kept marker) holds the input
// until the two-entry result buffer, which drains at most one beat per cycle, is down to one.
// Reset: arst_n clears the parser to expect the start-of-image marker and empties the buffer.
`include "jpeg_app_segment_stripper_macros.svh"

module jpeg_app_segment_stripper
	import jas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       kind,
	output logic       last_of_run
);

	// Parser state.
	logic [3:0]  phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] remain_q, remain_d;
	logic        keep_q, keep_d;

	// Result buffer: slot 0 is the head.
	res_t        slot0_q, slot1_q;
	logic [1:0]  count_q;

	logic        in_acc, out_acc;
	logic [1:0]  n_res;
	res_t        res0, res1;
	logic [15:0] word;
	logic [15:0] len_word;
	logic [15:0] remain_dec;

	// Handshake: new bytes enter only when the buffer will be empty after this cycle.
	assign out_valid = (count_q != 2'd0);
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready);
	assign in_acc    = in_valid && in_ready;

	assign out_byte    = slot0_q.out_byte;
	assign kind        = slot0_q.kind;
	assign last_of_run = slot0_q.last;

	assign word       = {held_q, data_byte};
	assign len_word   = {len_hi_q, data_byte};
	assign remain_dec = remain_q - 16'd1;

	// Segment parser: next state and the results caused by this byte.
	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		len_hi_d = len_hi_q;
		remain_d = remain_q;
		keep_d   = keep_q;
		n_res    = 2'd0;
		res0     = '0;
		res1     = '0;
		case (phase_q)
			PH_SOI_HI: begin
				held_d  = data_byte;
				phase_d = PH_SOI_LO;
			end
			PH_SOI_LO: begin
				if (word == MARK_SOI) begin
					phase_d = PH_MARK_HI;
				end else begin
					res0.kind = KIND_ERROR;
					n_res     = 2'd1;
					phase_d   = PH_DEAD;
				end
			end
			PH_MARK_HI: begin
				held_d  = data_byte;
				phase_d = PH_MARK_LO;
			end
			PH_MARK_LO: begin
				res0.out_byte = held_q;
				res1.out_byte = data_byte;
				if (word == MARK_SOS) begin
					n_res   = 2'd2;
					phase_d = PH_PASS;
				end else begin
					keep_d  = ((word & APP_MASK) != APP_BASE);
					n_res   = ((word & APP_MASK) != APP_BASE) ? 2'd2 : 2'd0;
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				len_hi_d      = data_byte;
				res0.out_byte = data_byte;
				n_res         = keep_q ? 2'd1 : 2'd0;
				phase_d       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				res0.out_byte = data_byte;
				n_res         = keep_q ? 2'd1 : 2'd0;
				// A length below two counts as an empty payload.
				remain_d = (len_word >= 16'd2) ? (len_word - 16'd2) : 16'd0;
				phase_d  = (len_word > 16'd2) ? PH_PAYLOAD : PH_MARK_HI;
			end
			PH_PAYLOAD: begin
				res0.out_byte = data_byte;
				n_res         = keep_q ? 2'd1 : 2'd0;
				remain_d      = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_d = PH_MARK_HI;
				end
			end
			PH_PASS: begin
				res0.out_byte = data_byte;
				n_res         = 2'd1;
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// Parser registers advance on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOI_HI;
			held_q   <= '0;
			len_hi_q <= '0;
			remain_q <= '0;
			keep_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			held_q   <= held_d;
			len_hi_q <= len_hi_d;
			remain_q <= remain_d;
			keep_q   <= keep_d;
		end
	end

	// Buffer fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (in_acc && (n_res != 2'd0)) begin
			count_q <= n_res;
		end else if (out_acc) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Buffer payload: a push always lands in an empty buffer.
	always_ff @(posedge clk) begin
		if (in_acc && (n_res != 2'd0)) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end
	end

	`JAS_ASSERT_NOW(a_count_range, 1'b1, count_q != 2'd3, "result buffer count out of range")
	`JAS_ASSERT_NOW(a_push_empty, in_acc, (count_q == 2'd0) || ((count_q == 2'd1) && out_acc), "byte accepted while buffer would still hold results")
	`JAS_ASSERT_NEXT(a_dead_sticks, phase_q == PH_DEAD, phase_q == PH_DEAD, "parser left the dead phase without reset")
	`JAS_ASSERT_NOW(a_error_beat, out_valid && (kind == KIND_ERROR), (out_byte == 8'd0) && last_of_run, "error beat must carry zero byte and end its run")
	`JAS_ASSERT_NOW(a_two_beat_head, out_valid && (count_q == 2'd2), !last_of_run, "head of a two-beat run marked last")

endmodule
